// File: src/oklch_hue_to_linear_rgb_defines.svh
// Assertion macros shared by the hue-to-linear-RGB block.
`ifndef OKLCH_HUE_TO_LINEAR_RGB_DEFINES_SVH
`define OKLCH_HUE_TO_LINEAR_RGB_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define OHL_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed delay in cycles.
`define OHL_ASSERT_AFTER(name, clk, rst, ante, delay, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(delay) (cons)) \
      else $error(msg);

`endif

// File: src/ohlrgb_pkg.sv
// Constants, register codes and elaboration-time table functions for the hue-to-RGB block.
package ohlrgb_pkg;

   localparam int ANGLE_TABLE_BITS_DEFAULT = 10;
   localparam int FRACTION_BITS_DEFAULT    = 16;

   localparam int HUE_BITS       = 16;
   localparam int CFG_BITS       = 16;
   localparam int RGB_BITS       = 20;
   localparam int CSR_INDEX_BITS = 2;

   localparam int RGB_MAX = 524287;
   localparam int RGB_MIN = -524288;

   localparam logic [CFG_BITS-1:0] LIGHTNESS_RESET  = 16'd53740;
   localparam logic [CFG_BITS-1:0] CHROMA_RESET     = 16'd9830;
   localparam logic [CFG_BITS-1:0] HUE_OFFSET_RESET = 16'd4694;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LIGHTNESS  = 2'd0,
      CSR_CHROMA     = 2'd1,
      CSR_HUE_OFFSET = 2'd2
   } csr_reg_type;

   localparam longint unsigned Q30One       = 64'd1073741824;
   localparam longint unsigned PiQuarterQ30 = 64'd843314857;
   localparam longint unsigned OctOne       = 64'd536870912;
   localparam longint unsigned DecOne       = 64'd10000000000;
   localparam longint unsigned DecHalf      = 64'd5000000000;

   // Decimal constant, scaled by 1e10, rounded half up to the working fraction.
   function automatic longint coef_q(input longint unsigned mag10, input bit neg,
                                     input int frac_bits);
      longint unsigned m;
      m = ((mag10 << frac_bits) + DecHalf) / DecOne;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // Sine series in unsigned Q30, Horner form, truncating at every step.
   function automatic longint unsigned series_sin(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = (x * x) >> 30;
      t  = Q30One;
      t  = Q30One - ((x2 * t) >> 30) / 110;
      t  = Q30One - ((x2 * t) >> 30) / 72;
      t  = Q30One - ((x2 * t) >> 30) / 42;
      t  = Q30One - ((x2 * t) >> 30) / 20;
      t  = Q30One - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
   endfunction

   // Cosine series in unsigned Q30.
   function automatic longint unsigned series_cos(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = (x * x) >> 30;
      t  = Q30One;
      t  = Q30One - ((x2 * t) >> 30) / 132;
      t  = Q30One - ((x2 * t) >> 30) / 90;
      t  = Q30One - ((x2 * t) >> 30) / 56;
      t  = Q30One - ((x2 * t) >> 30) / 30;
      t  = Q30One - ((x2 * t) >> 30) / 12;
      t  = Q30One - ((x2 * t) >> 30) / 2;
      return t;
   endfunction

   function automatic longint q30_to_qf(input longint unsigned v, input bit neg,
                                        input int frac_bits);
      longint unsigned r;
      r = (v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // Table entry: sine (want_sin set) or cosine of index / 2^table_bits turns, in QF.
   function automatic longint sincos_q(input longint unsigned index, input int table_bits,
                                       input int frac_bits, input bit want_sin);
      longint unsigned u;
      longint unsigned oct;
      longint unsigned f;
      longint unsigned x;
      longint unsigned sp;
      longint unsigned cp;
      longint s;
      longint c;
      u   = (index << (32 - table_bits)) & 64'hFFFF_FFFF;
      oct = u >> 29;
      f   = u & (OctOne - 64'd1);
      if (oct[0]) begin
         x  = ((OctOne - f) * PiQuarterQ30) >> 29;
         sp = series_cos(x);
         cp = series_sin(x);
      end else begin
         x  = (f * PiQuarterQ30) >> 29;
         sp = series_sin(x);
         cp = series_cos(x);
      end
      case (oct >> 1)
         64'd0: begin
            s = q30_to_qf(sp, 1'b0, frac_bits);
            c = q30_to_qf(cp, 1'b0, frac_bits);
         end
         64'd1: begin
            s = q30_to_qf(cp, 1'b0, frac_bits);
            c = q30_to_qf(sp, 1'b1, frac_bits);
         end
         64'd2: begin
            s = q30_to_qf(sp, 1'b1, frac_bits);
            c = q30_to_qf(cp, 1'b1, frac_bits);
         end
         default: begin
            s = q30_to_qf(cp, 1'b1, frac_bits);
            c = q30_to_qf(sp, 1'b0, frac_bits);
         end
      endcase
      return want_sin ? s : c;
   endfunction

endpackage

// File: src/oklch_hue_to_linear_rgb.sv
// Top level: OkLCh hue position to saturated linear RGB, seven-stage pipeline.
//
// Use of the block
//   Input channel: drive req_hue_position (turns, Q0.16) and raise start; the beat is
//   taken at a rising edge where start is high and busy is low. busy is high only
//   while reset is applied and in the cycle after it, so one beat can enter per clock.
//   Result channel: rsp_valid marks one cycle in which rsp_red_linear,
//   rsp_green_linear and rsp_blue_linear (signed Q3.16, saturated) hold the result.
//   The receiver cannot hold results off; every accepted beat gives exactly one result.
//   Path: an accepted beat passes seven register stages (table read, chroma products,
//   LMS matrix, square, cube, RGB matrix, rounding and saturation) to the ports.
//   Throughput: one beat per cycle, as no stage ever stalls.
//   Configuration: csr_index / csr_wdata with csr_valid; csr_ready is always high.
//   Index 0 lightness, 1 chroma, 2 hue offset; other indexes are ignored. Write only
//   while no beat is in flight.
//   Reset: synchronous, clears every stage valid bit and loads the register defaults.
//   The sine/cosine table is a constant ROM, so no clearing pass follows reset.

`include "oklch_hue_to_linear_rgb_defines.svh"

module oklch_hue_to_linear_rgb #(
   parameter int ANGLE_TABLE_BITS = ohlrgb_pkg::ANGLE_TABLE_BITS_DEFAULT,
   parameter int FRACTION_BITS    = ohlrgb_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [ohlrgb_pkg::HUE_BITS-1:0]           req_hue_position,
   output logic                                      rsp_valid,
   output logic signed [ohlrgb_pkg::RGB_BITS-1:0]    rsp_red_linear,
   output logic signed [ohlrgb_pkg::RGB_BITS-1:0]    rsp_green_linear,
   output logic signed [ohlrgb_pkg::RGB_BITS-1:0]    rsp_blue_linear,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ohlrgb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ohlrgb_pkg::CFG_BITS-1:0]           csr_wdata
);

   localparam int FB  = FRACTION_BITS;
   localparam int AB  = ANGLE_TABLE_BITS;
   localparam int HB  = ohlrgb_pkg::HUE_BITS;
   localparam int OB  = ohlrgb_pkg::RGB_BITS;

   // Widths of the fixed-point values at each stage.
   localparam int TW  = FB + 2;         // sin, cos, a, b: magnitude up to one
   localparam int UW  = FB + 1;         // L and C in QF, unsigned
   localparam int KW  = FB + 4;         // matrix coefficients, magnitude below 8
   localparam int LW  = FB + 3;         // l', m', s': magnitude below 4
   localparam int SQW = FB + 4;         // squares: below 8
   localparam int CUW = FB + 5;         // cubes: below 16
   localparam int RW  = FB + 10;        // RGB before rounding to Q16: below 512
   localparam int BPW = 2 * FB + 4;
   localparam int CPW = 2 * FB + 8;
   localparam int DPW = 2 * LW;
   localparam int EPW = SQW + LW;
   localparam int FPW = 2 * FB + 11;
   localparam int CVW = FB + 17;

   // Scaling between Q0.16 / Q16 and the working fraction.
   localparam int UP  = (FB >= 16) ? FB - 16 : 0;
   localparam int DN  = (FB < 16) ? 16 - FB : 0;
   localparam int XW  = RW + DN;
   localparam int QW  = XW - UP;

   localparam int NSTAGE = 7;

   localparam longint RND     = 64'sd1 <<< (FB - 1);
   localparam longint HALF_DN = (64'sd1 <<< DN) >>> 1;
   localparam longint HALF_UP = (64'sd1 <<< UP) >>> 1;
   localparam longint ONE_Q   = 64'sd1 <<< FB;

   localparam logic signed [TW-1:0] ONE_T  = TW'(ONE_Q);
   localparam logic signed [QW-1:0] SAT_HI = QW'(ohlrgb_pkg::RGB_MAX);
   localparam logic signed [QW-1:0] SAT_LO = QW'(ohlrgb_pkg::RGB_MIN);

   // OkLab to LMS (a and b columns; the L column is one).
   localparam logic signed [KW-1:0] K_A [3] = '{
      KW'(ohlrgb_pkg::coef_q(64'd3963377774, 1'b0, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd1055613458, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd894841775, 1'b1, FB))
   };
   localparam logic signed [KW-1:0] K_B [3] = '{
      KW'(ohlrgb_pkg::coef_q(64'd2158037573, 1'b0, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd638541728, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd12914855480, 1'b1, FB))
   };

   // LMS cubes to linear sRGB, row-major.
   localparam logic signed [KW-1:0] K_OUT [9] = '{
      KW'(ohlrgb_pkg::coef_q(64'd40767416621, 1'b0, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd33077115913, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd2309699292, 1'b0, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd12684380046, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd26097574011, 1'b0, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd3413193965, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd41960863, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd7034186147, 1'b1, FB)),
      KW'(ohlrgb_pkg::coef_q(64'd17076147010, 1'b0, FB))
   };

   // Configuration registers and their QF forms.
   logic [ohlrgb_pkg::CFG_BITS-1:0] lightness_ff;
   logic [ohlrgb_pkg::CFG_BITS-1:0] chroma_ff;
   logic [ohlrgb_pkg::CFG_BITS-1:0] hue_offset_ff;
   logic [UW-1:0]                   lightness_qf_in, lightness_qf_ff;
   logic [UW-1:0]                   chroma_qf_in, chroma_qf_ff;
   logic [CVW-1:0]                  lightness_wide;
   logic [CVW-1:0]                  chroma_wide;

   logic                            busy_ff;
   logic                            accept;
   logic [NSTAGE-1:0]               valid_ff;

   // Stage data.
   logic [HB-1:0]                   angle;
   logic [AB-1:0]                   rom_addr;
   logic [2*TW-1:0]                 sincos_rom [2**AB];
   logic [2*TW-1:0]                 sincos_ff;
   logic signed [TW-1:0]            sin_val, cos_val;
   logic signed [BPW-1:0]           prod_a, prod_b;
   logic signed [TW-1:0]            a_in, a_ff, b_in, b_ff;
   logic signed [CPW-1:0]           lms_sum [3];
   logic signed [LW-1:0]            lms_in [3];
   logic signed [LW-1:0]            lms_ff [3];
   logic signed [DPW-1:0]           sq_prod [3];
   logic signed [SQW-1:0]           sq_in [3];
   logic signed [SQW-1:0]           sq_ff [3];
   logic signed [LW-1:0]            lms_d_ff [3];
   logic signed [EPW-1:0]           cube_prod [3];
   logic signed [CUW-1:0]           cube_in [3];
   logic signed [CUW-1:0]           cube_ff [3];
   logic signed [FPW-1:0]           rgb_sum [3];
   logic signed [RW-1:0]            rgb_in [3];
   logic signed [RW-1:0]            rgb_ff [3];
   logic signed [XW-1:0]            fin_wide [3];
   logic signed [QW-1:0]            fin_q [3];
   logic signed [OB-1:0]            out_in [3];
   logic signed [OB-1:0]            out_ff [3];

   // ---------------------------------------------------------------- control
   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         valid_ff      <= '0;
         lightness_ff  <= ohlrgb_pkg::LIGHTNESS_RESET;
         chroma_ff     <= ohlrgb_pkg::CHROMA_RESET;
         hue_offset_ff <= ohlrgb_pkg::HUE_OFFSET_RESET;
      end else begin
         busy_ff  <= 1'b0;
         // Advance the valid bits with the data; nothing ever stalls.
         valid_ff <= {valid_ff[NSTAGE-2:0], accept};
         if (csr_valid) begin
            case (csr_index)
               ohlrgb_pkg::CSR_LIGHTNESS:  lightness_ff  <= csr_wdata;
               ohlrgb_pkg::CSR_CHROMA:     chroma_ff     <= csr_wdata;
               ohlrgb_pkg::CSR_HUE_OFFSET: hue_offset_ff <= csr_wdata;
               default: ;  // unmapped index: drop the write
            endcase
         end
      end
   end

   // L and C to the working fraction: shift up, or round half up when narrower.
   always_comb begin
      lightness_wide  = (CVW'(lightness_ff) << UP) + CVW'(HALF_DN);
      chroma_wide     = (CVW'(chroma_ff) << UP) + CVW'(HALF_DN);
      lightness_qf_in = UW'(lightness_wide >> DN);
      chroma_qf_in    = UW'(chroma_wide >> DN);
   end

   // ---------------------------------------------------------------- stage 0: table read
   // Hue angle wraps modulo one turn; its top bits address the sine/cosine ROM.
   assign angle    = req_hue_position + hue_offset_ff;
   assign rom_addr = angle[HB-1 -: AB];

   for (genvar gi = 0; gi < 2**AB; gi++) begin : g_rom
      assign sincos_rom[gi] = {TW'(ohlrgb_pkg::sincos_q(gi, AB, FB, 1'b1)),
                               TW'(ohlrgb_pkg::sincos_q(gi, AB, FB, 1'b0))};
   end

   // ---------------------------------------------------------------- stage 1: a = C cos, b = C sin
   assign sin_val = signed'(sincos_ff[2*TW-1:TW]);
   assign cos_val = signed'(sincos_ff[TW-1:0]);

   always_comb begin
      prod_a = BPW'(signed'({1'b0, chroma_qf_ff})) * BPW'(cos_val);
      prod_b = BPW'(signed'({1'b0, chroma_qf_ff})) * BPW'(sin_val);
      a_in   = TW'((prod_a + BPW'(RND)) >>> FB);
      b_in   = TW'((prod_b + BPW'(RND)) >>> FB);
   end

   // ---------------------------------------------------------------- stage 2: LMS matrix
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lms_sum[i] = (CPW'(signed'({1'b0, lightness_qf_ff})) <<< FB)
                    + CPW'(K_A[i]) * CPW'(a_ff)
                    + CPW'(K_B[i]) * CPW'(b_ff)
                    + CPW'(RND);
         lms_in[i]  = LW'(lms_sum[i] >>> FB);
      end
   end

   // ---------------------------------------------------------------- stages 3 and 4: cube
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_prod[i]   = DPW'(lms_ff[i]) * DPW'(lms_ff[i]);
         sq_in[i]     = SQW'((sq_prod[i] + DPW'(RND)) >>> FB);
         cube_prod[i] = EPW'(sq_ff[i]) * EPW'(lms_d_ff[i]);
         cube_in[i]   = CUW'((cube_prod[i] + EPW'(RND)) >>> FB);
      end
   end

   // ---------------------------------------------------------------- stage 5: RGB matrix
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rgb_sum[i] = FPW'(K_OUT[3*i])     * FPW'(cube_ff[0])
                    + FPW'(K_OUT[3*i + 1]) * FPW'(cube_ff[1])
                    + FPW'(K_OUT[3*i + 2]) * FPW'(cube_ff[2])
                    + FPW'(RND);
         rgb_in[i]  = RW'(rgb_sum[i] >>> FB);
      end
   end

   // ---------------------------------------------------------------- stage 6: to Q16, saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin_wide[i] = (XW'(rgb_ff[i]) <<< DN) + XW'(HALF_UP);
         fin_q[i]    = QW'(fin_wide[i] >>> UP);
         if (fin_q[i] > SAT_HI) begin
            out_in[i] = OB'(SAT_HI);
         end else if (fin_q[i] < SAT_LO) begin
            out_in[i] = OB'(SAT_LO);
         end else begin
            out_in[i] = OB'(fin_q[i]);
         end
      end
   end

   // Stage payload registers: no reset, the valid bits qualify them.
   always_ff @(posedge clock) begin
      lightness_qf_ff <= lightness_qf_in;
      chroma_qf_ff    <= chroma_qf_in;
      sincos_ff       <= sincos_rom[rom_addr];
      a_ff            <= a_in;
      b_ff            <= b_in;
      for (int i = 0; i < 3; i++) begin
         lms_ff[i]   <= lms_in[i];
         sq_ff[i]    <= sq_in[i];
         lms_d_ff[i] <= lms_ff[i];
         cube_ff[i]  <= cube_in[i];
         rgb_ff[i]   <= rgb_in[i];
         out_ff[i]   <= out_in[i];
      end
   end

   assign rsp_red_linear   = out_ff[0];
   assign rsp_green_linear = out_ff[1];
   assign rsp_blue_linear  = out_ff[2];

   // ---------------------------------------------------------------- checks
   `OHL_ASSERT_AFTER(a_accept_gives_result, clock, reset, accept, NSTAGE, rsp_valid, "accepted beat lost")
   `OHL_ASSERT_IMPLY(a_result_had_accept, clock, reset, rsp_valid, $past(accept, NSTAGE), "result without beat")
   `OHL_ASSERT_IMPLY(a_ab_in_range, clock, reset, valid_ff[1], (a_ff <= ONE_T) && (a_ff >= -ONE_T) && (b_ff <= ONE_T) && (b_ff >= -ONE_T), "a or b beyond chroma bound")

endmodule

// File: tb/oklch_hue_to_linear_rgb_tb.sv
// Self-checking bench for the OkLCh hue circle to linear RGB pipeline.
`timescale 1ns / 1ps

module oklch_hue_to_linear_rgb_tb;

   localparam int TABLE_BITS    = ohlrgb_pkg::ANGLE_TABLE_BITS_DEFAULT;
   localparam int FRAC          = ohlrgb_pkg::FRACTION_BITS_DEFAULT;
   localparam int PIPE_LATENCY  = 7;
   localparam int BEATS_PER_SET = 130;
   localparam int LAST_SET      = 8;

   localparam int HUE_BITS       = ohlrgb_pkg::HUE_BITS;
   localparam int CFG_BITS       = ohlrgb_pkg::CFG_BITS;
   localparam int RGB_BITS       = ohlrgb_pkg::RGB_BITS;
   localparam int CSR_INDEX_BITS = ohlrgb_pkg::CSR_INDEX_BITS;

   // Index with no register behind it: the block must drop writes to it.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   localparam longint unsigned UNIT_Q30       = 64'd1 << 30;
   localparam longint unsigned OCTANT_Q29     = 64'd1 << 29;
   localparam longint unsigned QUARTER_PI_Q30 = 64'd843314857;
   localparam longint unsigned DEC_SCALE      = 64'd10000000000;

   typedef struct packed {
      logic signed [RGB_BITS-1:0] red;
      logic signed [RGB_BITS-1:0] green;
      logic signed [RGB_BITS-1:0] blue;
   } rgb_triple_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [HUE_BITS-1:0]         req_hue_position = '0;
   logic                        rsp_valid;
   logic signed [RGB_BITS-1:0]  rsp_red_linear;
   logic signed [RGB_BITS-1:0]  rsp_green_linear;
   logic signed [RGB_BITS-1:0]  rsp_blue_linear;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CFG_BITS-1:0]         csr_wdata = '0;

   // Shadow copies of the three registers, loaded with the reset defaults.
   logic [CFG_BITS-1:0] cfg_lightness  = ohlrgb_pkg::LIGHTNESS_RESET;
   logic [CFG_BITS-1:0] cfg_chroma     = ohlrgb_pkg::CHROMA_RESET;
   logic [CFG_BITS-1:0] cfg_hue_offset = ohlrgb_pkg::HUE_OFFSET_RESET;

   logic [HUE_BITS-1:0] hue_pending_q [$];
   rgb_triple_type      rgb_expect_q [$];
   int unsigned         beats_queued = 0;
   int unsigned         beats_taken  = 0;
   int unsigned         send_gap     = 0;
   bit                  feed_idle    = 1'b1;
   int unsigned         fail_count   = 0;

   always #5 clock = ~clock;

   oklch_hue_to_linear_rgb #(
      .ANGLE_TABLE_BITS(TABLE_BITS),
      .FRACTION_BITS   (FRAC)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_hue_position(req_hue_position),
      .rsp_valid       (rsp_valid),
      .rsp_red_linear  (rsp_red_linear),
      .rsp_green_linear(rsp_green_linear),
      .rsp_blue_linear (rsp_blue_linear),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Colour arithmetic, working fraction FRAC bits
   // ---------------------------------------------------------------------------------

   // Shift right with rounding half up (ties go toward plus infinity).
   function automatic longint round_half_up(input longint v, input int sh);
      if (sh == 0)
         return v;
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint fx_mul(input longint x, input longint y);
      return round_half_up(x * y, FRAC);
   endfunction

   // Three products summed at full precision, rounded once.
   function automatic longint fx_dot3(input longint k0, v0, k1, v1, k2, v2);
      return round_half_up(k0 * v0 + k1 * v1 + k2 * v2, FRAC);
   endfunction

   // Matrix coefficient given as its decimal value times 1e10.
   function automatic longint fx_coef(input longint unsigned mag10, input bit neg);
      longint unsigned m;
      m = ((mag10 << FRAC) + DEC_SCALE / 2) / DEC_SCALE;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint fx_cube(input longint v);
      return fx_mul(fx_mul(v, v), v);
   endfunction

   // Truncating Horner evaluation in unsigned Q30 over the first octant. The divisor
   // of each step is n(n+1): sine runs n = 10..2, cosine n = 11..1.
   function automatic longint unsigned taylor_q30(input longint unsigned x,
                                                  input bit want_sin);
      longint unsigned xx;
      longint unsigned acc;
      int              n;
      xx  = (x * x) >> 30;
      acc = UNIT_Q30;
      for (n = want_sin ? 10 : 11; n >= 1; n -= 2)
         acc = UNIT_Q30 - ((xx * acc) >> 30) / longint'(unsigned'(n * (n + 1)));
      if (want_sin)
         return (x * acc) >> 30;
      return acc;
   endfunction

   function automatic longint q30_to_fx(input longint unsigned v, input bit neg);
      longint unsigned r;
      r = (v + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // Back to Q3.16 and clip to the 20-bit range.
   function automatic logic signed [RGB_BITS-1:0] to_q316(input longint v);
      longint q;
      q = round_half_up(v, FRAC - 16);
      if (q > ohlrgb_pkg::RGB_MAX)
         q = ohlrgb_pkg::RGB_MAX;
      if (q < ohlrgb_pkg::RGB_MIN)
         q = ohlrgb_pkg::RGB_MIN;
      return q[RGB_BITS-1:0];
   endfunction

   function automatic rgb_triple_type predict_linear_rgb(input logic [HUE_BITS-1:0] hue);
      logic [HUE_BITS-1:0] angle;
      logic [31:0]         turn;
      logic [2:0]          oct;
      longint unsigned     frac_part;
      longint unsigned     x;
      longint unsigned     s_mag;
      longint unsigned     c_mag;
      longint              sin_fx, cos_fx, l_fx, c_fx, a_fx, b_fx, one;
      longint              lp, mp, sp, l3, m3, s3;
      rgb_triple_type      rgb;
      angle     = hue + cfg_hue_offset;
      // Table index is the top bits of the angle, placed back as a 32-bit turn.
      turn      = {angle[HUE_BITS-1 -: TABLE_BITS], {(32 - TABLE_BITS){1'b0}}};
      oct       = turn[31:29];
      frac_part = turn[28:0];
      // Odd octants mirror onto the first, with sine and cosine swapped.
      if (oct[0]) begin
         x     = ((OCTANT_Q29 - frac_part) * QUARTER_PI_Q30) >> 29;
         s_mag = taylor_q30(x, 1'b0);
         c_mag = taylor_q30(x, 1'b1);
      end else begin
         x     = (frac_part * QUARTER_PI_Q30) >> 29;
         s_mag = taylor_q30(x, 1'b1);
         c_mag = taylor_q30(x, 1'b0);
      end
      case (oct[2:1])
         2'd0: begin
            sin_fx = q30_to_fx(s_mag, 1'b0);
            cos_fx = q30_to_fx(c_mag, 1'b0);
         end
         2'd1: begin
            sin_fx = q30_to_fx(c_mag, 1'b0);
            cos_fx = q30_to_fx(s_mag, 1'b1);
         end
         2'd2: begin
            sin_fx = q30_to_fx(s_mag, 1'b1);
            cos_fx = q30_to_fx(c_mag, 1'b1);
         end
         default: begin
            sin_fx = q30_to_fx(c_mag, 1'b1);
            cos_fx = q30_to_fx(s_mag, 1'b0);
         end
      endcase
      l_fx = longint'(cfg_lightness) <<< (FRAC - 16);
      c_fx = longint'(cfg_chroma) <<< (FRAC - 16);
      a_fx = fx_mul(c_fx, cos_fx);
      b_fx = fx_mul(c_fx, sin_fx);
      one  = longint'(1) <<< FRAC;

      lp = fx_dot3(one, l_fx, fx_coef(64'd3963377774, 1'b0), a_fx,
                   fx_coef(64'd2158037573, 1'b0), b_fx);
      mp = fx_dot3(one, l_fx, fx_coef(64'd1055613458, 1'b1), a_fx,
                   fx_coef(64'd638541728, 1'b1), b_fx);
      sp = fx_dot3(one, l_fx, fx_coef(64'd894841775, 1'b1), a_fx,
                   fx_coef(64'd12914855480, 1'b1), b_fx);
      l3 = fx_cube(lp);
      m3 = fx_cube(mp);
      s3 = fx_cube(sp);

      rgb.red   = to_q316(fx_dot3(fx_coef(64'd40767416621, 1'b0), l3,
                                  fx_coef(64'd33077115913, 1'b1), m3,
                                  fx_coef(64'd2309699292, 1'b0), s3));
      rgb.green = to_q316(fx_dot3(fx_coef(64'd12684380046, 1'b1), l3,
                                  fx_coef(64'd26097574011, 1'b0), m3,
                                  fx_coef(64'd3413193965, 1'b1), s3));
      rgb.blue  = to_q316(fx_dot3(fx_coef(64'd41960863, 1'b1), l3,
                                  fx_coef(64'd7034186147, 1'b1), m3,
                                  fx_coef(64'd17076147010, 1'b0), s3));
      return rgb;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver: one beat per edge when nothing holds it back
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         send_gap = 0;
      end else begin
         // The beat on the ports is taken at this edge: predict it with the live shadows.
         if (start && !busy) begin
            rgb_expect_q.push_back(predict_linear_rgb(req_hue_position));
            beats_taken++;
         end
         // Hold a beat that has not been taken; otherwise idle or advance.
         if (!start || !busy) begin
            if (send_gap != 0) begin
               send_gap--;
               start <= 1'b0;
            end else if (hue_pending_q.size() != 0) begin
               req_hue_position <= hue_pending_q.pop_front();
               start <= 1'b1;
               if (feed_idle && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 11);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result monitor: every strobed beat must match the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rgb_triple_type want;
      if (!reset && rsp_valid) begin
         if (rgb_expect_q.size() == 0) begin
            $error("result beat with nothing predicted: %0d %0d %0d",
                   rsp_red_linear, rsp_green_linear, rsp_blue_linear);
            fail_count++;
         end else begin
            want = rgb_expect_q.pop_front();
            if (rsp_red_linear !== want.red) begin
               $error("red_linear: expected %0d, got %0d", want.red, rsp_red_linear);
               fail_count++;
            end
            if (rsp_green_linear !== want.green) begin
               $error("green_linear: expected %0d, got %0d", want.green, rsp_green_linear);
               fail_count++;
            end
            if (rsp_blue_linear !== want.blue) begin
               $error("blue_linear: expected %0d, got %0d", want.blue, rsp_blue_linear);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------------------
   task automatic queue_hue(input logic [HUE_BITS-1:0] hue);
      hue_pending_q.push_back(hue);
      beats_queued++;
   endtask

   // Call just after a rising edge; returns at the next edge after the write has gone in,
   // so back-to-back calls never raise and drop valid in the same step.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ohlrgb_pkg::CSR_LIGHTNESS:  cfg_lightness  = value;
         ohlrgb_pkg::CSR_CHROMA:     cfg_chroma     = value;
         ohlrgb_pkg::CSR_HUE_OFFSET: cfg_hue_offset = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Wait until every queued beat has been taken and answered.
   task automatic drain_pipeline();
      while (beats_taken != beats_queued || rgb_expect_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset defaults: field extremes, alternating bits, walking
      // ones, and positions whose angle wraps exactly to zero and to half a turn.
      queue_hue(16'h0000);
      queue_hue(16'hFFFF);
      queue_hue(16'h5555);
      queue_hue(16'hAAAA);
      for (n = 0; n < HUE_BITS; n++)
         queue_hue(16'h0001 << n);
      queue_hue(16'h0000 - ohlrgb_pkg::HUE_OFFSET_RESET);
      queue_hue(16'h8000 - ohlrgb_pkg::HUE_OFFSET_RESET);

      for (phase = 0; phase <= LAST_SET; phase++) begin
         if (phase != 0) begin
            drain_pipeline();
            case (phase)
               // Black: zero lightness and chroma; also poke the unused index.
               1: begin
                  write_csr(ohlrgb_pkg::CSR_LIGHTNESS, 16'h0000);
                  write_csr(ohlrgb_pkg::CSR_CHROMA, 16'h0000);
                  write_csr(ohlrgb_pkg::CSR_HUE_OFFSET, 16'h0000);
                  write_csr(CSR_SPARE, 16'($urandom));
               end
               // Everything at full scale: chroma beyond its nominal top, and the
               // blue channel driven into saturation.
               2: begin
                  write_csr(ohlrgb_pkg::CSR_LIGHTNESS, 16'hFFFF);
                  write_csr(ohlrgb_pkg::CSR_CHROMA, 16'hFFFF);
                  write_csr(ohlrgb_pkg::CSR_HUE_OFFSET, 16'hFFFF);
                  write_csr(CSR_SPARE, 16'hFFFF);
               end
               3: begin
                  write_csr(ohlrgb_pkg::CSR_CHROMA, 16'h8000);
                  write_csr(ohlrgb_pkg::CSR_HUE_OFFSET, 16'h8000);
               end
               // Zero lightness with full chroma gives negative LMS values to cube.
               4: begin
                  write_csr(ohlrgb_pkg::CSR_LIGHTNESS, 16'h0000);
                  write_csr(ohlrgb_pkg::CSR_CHROMA, 16'hFFFF);
                  write_csr(ohlrgb_pkg::CSR_HUE_OFFSET, 16'($urandom));
               end
               5: begin
                  write_csr(ohlrgb_pkg::CSR_LIGHTNESS, 16'hFFFF);
                  write_csr(ohlrgb_pkg::CSR_CHROMA, 16'h0000);
               end
               default: begin
                  write_csr(ohlrgb_pkg::CSR_LIGHTNESS, 16'($urandom));
                  write_csr(ohlrgb_pkg::CSR_CHROMA, 16'($urandom));
                  write_csr(ohlrgb_pkg::CSR_HUE_OFFSET, 16'($urandom));
                  if ($urandom_range(0, 1) == 0)
                     write_csr(CSR_SPARE, 16'($urandom));
               end
            endcase
         end
         // Run the closing set back to back with no idling.
         feed_idle = (phase != LAST_SET);
         for (n = 0; n < BEATS_PER_SET; n++)
            queue_hue(16'($urandom_range(0, 65535)));
      end

      drain_pipeline();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
